/* hdl/sqrtq_pkg.sv */
// ---------------------------------------------------------------------------
// sqrtq_pkg
// Shared types and constants for the Q16.16 digit-by-digit square root.
// ---------------------------------------------------------------------------
package sqrtq_pkg;

  localparam int VALUE_W = 32;
  localparam int ROOT_W  = 25;

  // first trial bit: bit 30 for large operands, bit 18 otherwise
  localparam logic [VALUE_W-1:0] BIG_MASK    = 32'hFFF0_0000;
  localparam logic [VALUE_W-1:0] HIGH_START  = 32'h4000_0000;
  localparam logic [VALUE_W-1:0] LOW_START   = 32'h0004_0000;
  // second pass starts at bit 14
  localparam logic [VALUE_W-1:0] PASS2_START = 32'h0000_4000;
  // remainder limit that triggers the half-lsb correction
  localparam logic [VALUE_W-1:0] REM_LIMIT   = 32'd65535;
  localparam logic [15:0]        HALF_LSB    = 16'h8000;

  // largest root magnitude, sqrt of 2^31 in q16.16
  localparam logic signed [ROOT_W-1:0] ROOT_MAX = 25'sd11863283;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PASS1,
    ST_CORR,
    ST_PASS2,
    ST_ROUND,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic search_shift;
    logic step;
    logic corr;
    logic round_up;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trial_gt_mag;
    logic trial_zero;
    logic trial_last;
  } status_t;

endpackage

/* hdl/sqrtq_datapath.sv */
// ---------------------------------------------------------------------------
// sqrtq_datapath
// Remainder, partial root and trial registers with one shared add/subtract
// step, plus the rounding register and the output word register.
// ---------------------------------------------------------------------------
module sqrtq_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sqrtq_pkg::cmd_t                        cmd_i,
  output sqrtq_pkg::status_t                     status_o,
  input  logic signed [sqrtq_pkg::VALUE_W-1:0]   value_in_i,
  input  logic                                   cfg_we_i,
  input  logic                                   round_enable_i,
  output logic signed [sqrtq_pkg::ROOT_W-1:0]    root_out_o
);

  logic [sqrtq_pkg::VALUE_W-1:0] rem_q, rem_d;
  logic [sqrtq_pkg::VALUE_W-1:0] root_q, root_d;
  logic [sqrtq_pkg::VALUE_W-1:0] trial_q, trial_d;
  logic                          neg_q, neg_d;
  logic [sqrtq_pkg::ROOT_W-1:0]  out_q, out_d;
  logic                          round_en_q;

  logic [sqrtq_pkg::VALUE_W-1:0] mag;
  logic [sqrtq_pkg::VALUE_W-1:0] step_sum;
  logic [sqrtq_pkg::VALUE_W:0]   step_diff;
  logic                          step_ge;
  logic [sqrtq_pkg::VALUE_W-1:0] corr_diff;

  // operand magnitude
  assign mag = value_in_i[sqrtq_pkg::VALUE_W-1]
             ? (sqrtq_pkg::VALUE_W'(0) - sqrtq_pkg::VALUE_W'(value_in_i))
             : sqrtq_pkg::VALUE_W'(value_in_i);

  // one recurrence step: compare remainder against root plus trial
  assign step_sum  = root_q + trial_q;
  assign step_diff = {1'b0, rem_q} - {1'b0, step_sum};
  assign step_ge   = ~step_diff[sqrtq_pkg::VALUE_W];

  // rem - root - 1, used by the half-lsb correction
  assign corr_diff = rem_q + ~root_q;

  // status back to the controller
  assign status_o.trial_gt_mag = (trial_q > rem_q);
  assign status_o.trial_zero   = (trial_q == '0);
  assign status_o.trial_last   = (trial_q[sqrtq_pkg::VALUE_W-1:2] == '0);

  // next values of the working registers
  always_comb begin
    rem_d   = rem_q;
    root_d  = root_q;
    trial_d = trial_q;
    neg_d   = neg_q;
    out_d   = out_q;
    if (cmd_i.load_in) begin
      rem_d   = mag;
      root_d  = '0;
      neg_d   = value_in_i[sqrtq_pkg::VALUE_W-1];
      trial_d = ((mag & sqrtq_pkg::BIG_MASK) != '0) ? sqrtq_pkg::HIGH_START
                                                     : sqrtq_pkg::LOW_START;
    end
    if (cmd_i.search_shift) begin
      trial_d = trial_q >> 2;
    end
    if (cmd_i.step) begin
      trial_d = trial_q >> 2;
      if (step_ge) begin
        rem_d  = step_diff[sqrtq_pkg::VALUE_W-1:0];
        root_d = (root_q >> 1) + trial_q;
      end else begin
        root_d = root_q >> 1;
      end
    end
    if (cmd_i.corr) begin
      trial_d = sqrtq_pkg::PASS2_START;
      if (rem_q > sqrtq_pkg::REM_LIMIT) begin
        rem_d  = {corr_diff[15:0], sqrtq_pkg::HALF_LSB};
        root_d = {root_q[15:0], sqrtq_pkg::HALF_LSB};
      end else begin
        rem_d  = {rem_q[15:0], 16'h0000};
        root_d = {root_q[15:0], 16'h0000};
      end
    end
    if (cmd_i.round_up) begin
      if (round_en_q && (rem_q > root_q)) begin
        root_d = root_q + sqrtq_pkg::VALUE_W'(1);
      end
    end
    if (cmd_i.load_out) begin
      out_d = neg_q ? (sqrtq_pkg::ROOT_W'(0) - root_q[sqrtq_pkg::ROOT_W-1:0])
                    : root_q[sqrtq_pkg::ROOT_W-1:0];
    end
  end

  // working and output registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    root_q  <= root_d;
    trial_q <= trial_d;
    neg_q   <= neg_d;
    out_q   <= out_d;
  end

  // rounding mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      round_en_q <= round_enable_i;
    end
  end

  assign root_out_o = $signed(out_q);

endmodule

/* hdl/sqrtq_ctrl.sv */
// ---------------------------------------------------------------------------
// sqrtq_ctrl
// Sequencer for the two root passes, the correction and the rounding, and
// the valid flag of the output word register.
// ---------------------------------------------------------------------------
module sqrtq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  sqrtq_pkg::status_t   status_i,
  output sqrtq_pkg::cmd_t      cmd_o
);

  sqrtq_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  assign slot_free = ~out_valid_q | out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sqrtq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sqrtq_pkg::ST_SEARCH;
      end
      sqrtq_pkg::ST_SEARCH: begin
        if (!status_i.trial_gt_mag) begin
          state_d = status_i.trial_zero ? sqrtq_pkg::ST_CORR : sqrtq_pkg::ST_PASS1;
        end
      end
      sqrtq_pkg::ST_PASS1: begin
        if (status_i.trial_last) state_d = sqrtq_pkg::ST_CORR;
      end
      sqrtq_pkg::ST_CORR: begin
        state_d = sqrtq_pkg::ST_PASS2;
      end
      sqrtq_pkg::ST_PASS2: begin
        if (status_i.trial_last) state_d = sqrtq_pkg::ST_ROUND;
      end
      sqrtq_pkg::ST_ROUND: begin
        state_d = sqrtq_pkg::ST_EMIT;
      end
      sqrtq_pkg::ST_EMIT: begin
        if (slot_free) state_d = sqrtq_pkg::ST_IDLE;
      end
      default: begin
        state_d = sqrtq_pkg::ST_IDLE;
      end
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sqrtq_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      sqrtq_pkg::ST_SEARCH: begin
        cmd_o.search_shift = status_i.trial_gt_mag;
      end
      sqrtq_pkg::ST_PASS1: begin
        cmd_o.step = 1'b1;
      end
      sqrtq_pkg::ST_CORR: begin
        cmd_o.corr = 1'b1;
      end
      sqrtq_pkg::ST_PASS2: begin
        cmd_o.step = 1'b1;
      end
      sqrtq_pkg::ST_ROUND: begin
        cmd_o.round_up = 1'b1;
      end
      sqrtq_pkg::ST_EMIT: begin
        cmd_o.load_out = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // output word valid flag
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sqrtq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/sqrt_q16_digit_by_digit.sv */
// ---------------------------------------------------------------------------
// sqrt_q16_digit_by_digit
// Q16.16 square root of the operand magnitude, negated for a negative
// operand, computed two bits per cycle on one shared subtractor.
// ---------------------------------------------------------------------------
//
//   channel | signals                          | direction | word
//   --------+----------------------------------+-----------+------------------
//   in      | in_valid_i, in_ready_o           | input     | value_in_i [31:0]
//   out     | out_valid_o, out_ready_i         | output    | root_out_o [24:0]
//   cfg     | cfg_valid_i, cfg_ready_o         | input     | round_enable_i
//
// One word at a time. The trial search starts at bit 30 when any of
// magnitude bits 31..20 is set, else at bit 18. The trial search and the
// first pass go together, since each search shift saves one first-pass
// step, then come the correction, eight second-pass steps, rounding and the
// output load. The next word can be taken in the cycle after the load.
// The output register lets the next word be accepted while a result waits;
// a second finished word waits in the load state until the register frees.
// Reset clears the sequencer and sets rounding on; no clearing pass.
// ---------------------------------------------------------------------------
module sqrt_q16_digit_by_digit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [sqrtq_pkg::VALUE_W-1:0] value_in_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 round_enable_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [sqrtq_pkg::ROOT_W-1:0]  root_out_o
);

  sqrtq_pkg::cmd_t    cmd;
  sqrtq_pkg::status_t status;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer
  sqrtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // root datapath
  sqrtq_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_in_i     (value_in_i),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .round_enable_i (round_enable_i),
    .root_out_o     (root_out_o)
  );

endmodule

/* hdl/sqrtq_checker.sv */
// ---------------------------------------------------------------------------
// sqrtq_checker
// Port-level checks for the Q16.16 square root, bound to the top level.
// ---------------------------------------------------------------------------
module sqrtq_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_o,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic signed [sqrtq_pkg::ROOT_W-1:0]  root_out_o
);

  // a waiting result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // a waiting result holds its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(root_out_o))
    else $error("result word changed while stalled");

  // one word in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a word is in progress");

  // root magnitude bounded by sqrt of 2^31
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (root_out_o <= sqrtq_pkg::ROOT_MAX) &&
                    (root_out_o >= -sqrtq_pkg::ROOT_MAX))
    else $error("root out of range");

endmodule

bind sqrt_q16_digit_by_digit sqrtq_checker u_sqrtq_checker (.*);

/* tb/sqrt_q16_digit_by_digit_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqrt_q16_digit_by_digit_test
// Drives signed Q16.16 words into the square root block under random
// handshake gaps and a long output hold-off. Every accepted word is turned
// into an expected root by a bit-exact digit-by-digit predictor, and each
// result word is compared with the oldest expected root. Rounding is
// switched between on and off while the block is idle.
// ---------------------------------------------------------------------------
module sqrt_q16_digit_by_digit_test;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 38;

  // expected roots in order of acceptance
  class root_scoreboard;
    logic signed [sqrtq_pkg::ROOT_W-1:0] pending[$];
    bit round_on;
    int errors;

    function new();
      round_on = 1'b1;
      errors = 0;
    endfunction

    function void set_round(bit on);
      round_on = on;
    endfunction

    // one two-bits-per-step pass of the restoring root recurrence
    function automatic void digit_pass(inout logic [31:0] rem, inout logic [31:0] acc,
                                       input logic [31:0] trial);
      logic [31:0] sum;
      while (trial != 0) begin
        sum = acc + trial;
        if (rem >= sum) begin
          rem = rem - sum;
          acc = (acc >> 1) + trial;
        end else begin
          acc = acc >> 1;
        end
        trial = trial >> 2;
      end
    endfunction

    function automatic logic signed [sqrtq_pkg::ROOT_W-1:0] root_of(logic [31:0] raw);
      logic        neg;
      logic [31:0] mag;
      logic [31:0] trial;
      logic [31:0] rem;
      logic [31:0] acc;
      neg = raw[31];
      mag = neg ? (32'd0 - raw) : raw;
      trial = ((mag & sqrtq_pkg::BIG_MASK) != 0) ? sqrtq_pkg::HIGH_START
                                                 : sqrtq_pkg::LOW_START;
      while (trial > mag) trial = trial >> 2;
      rem = mag;
      acc = 32'd0;
      digit_pass(rem, acc, trial);
      // move to the fractional pass, with half-lsb correction on a wide remainder
      if (rem > sqrtq_pkg::REM_LIMIT) begin
        rem = rem - acc;
        rem = (rem << 16) - {16'd0, sqrtq_pkg::HALF_LSB};
        acc = (acc << 16) + {16'd0, sqrtq_pkg::HALF_LSB};
      end else begin
        rem = rem << 16;
        acc = acc << 16;
      end
      digit_pass(rem, acc, sqrtq_pkg::PASS2_START);
      if (round_on && rem > acc) acc = acc + 32'd1;
      if (neg) acc = 32'd0 - acc;
      return acc[sqrtq_pkg::ROOT_W-1:0];
    endfunction

    function void note_value(logic [31:0] raw);
      pending.push_back(root_of(raw));
    endfunction

    function void check_root(logic signed [sqrtq_pkg::ROOT_W-1:0] got);
      logic signed [sqrtq_pkg::ROOT_W-1:0] want;
      if (pending.size() == 0) begin
        $display("%0t: root word %0d with none expected", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: root mismatch, expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic signed [sqrtq_pkg::VALUE_W-1:0] value_in_i;
  logic                                 cfg_valid_i;
  logic                                 cfg_ready_o;
  logic                                 round_enable_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic signed [sqrtq_pkg::ROOT_W-1:0]  root_out_o;

  root_scoreboard sb = new();
  int idle_pct;
  bit hold_req;
  int hold_left;
  int cycle_count;

  logic [31:0] corner_values [0:21] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF,
    32'h000F_FFFF, 32'h0010_0000, 32'hFFF0_0000, 32'h0001_0000,
    32'hFFFF_0000, 32'h0004_0000, 32'h0003_FFFF, 32'h0004_0001,
    32'h0100_0000, 32'h4000_0000, 32'h3FFF_FFFF, 32'h0000_0004,
    32'h0000_FFFF, 32'h5555_5555
  };

  sqrt_q16_digit_by_digit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_in_i     (value_in_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .round_enable_i (round_enable_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .root_out_o     (root_out_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // watch both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_value(value_in_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_root(root_out_o);
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  function automatic logic [31:0] random_value();
    logic [31:0] mag;
    int unsigned r;
    case ($urandom_range(3))
      0: return $urandom;
      1: mag = $urandom >> $urandom_range(31);
      2: begin
        // near perfect squares
        r = $urandom_range(46340);
        mag = r * r + $urandom_range(4) - 2;
      end
      default: mag = 32'h0010_0000 + $urandom_range(255) - 128;
    endcase
    return $urandom_range(1) ? (32'd0 - mag) : mag;
  endfunction

  // offer one word, idling at random first
  task automatic push_value(input logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_in_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering and wait for every expected root; the wait before the check
  // lets the last accepted word reach the scoreboard first
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_round(input bit on);
    cfg_valid_i <= 1'b1;
    round_enable_i <= on;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_round(on);
  endtask

  // stimulus
  initial begin
    in_valid_i = 1'b0;
    value_in_i = '0;
    cfg_valid_i = 1'b0;
    round_enable_i = 1'b0;
    rst_ni = 1'b0;
    hold_req = 1'b0;
    idle_pct = IDLE_PCT;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner operands with rounding on from reset
    for (int i = 0; i < $size(corner_values); i++) push_value(corner_values[i]);
    drain();

    write_round(1'b0);
    repeat (430) push_value(random_value());
    drain();

    // calm stretch, then a long result hold-off while words keep coming
    write_round(1'b1);
    idle_pct = 0;
    repeat (150) push_value(random_value());
    idle_pct = IDLE_PCT;
    hold_req = 1'b1;
    repeat (280) push_value(random_value());
    drain();

    write_round(1'b0);
    repeat (420) push_value(random_value());
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
